// ===== rtl/core/swdr_pkg.sv =====
// shared types and constants for the stack with duplicate removal
package swdr_pkg;

	localparam int DATA_W      = 32;
	localparam int MAX_RESULTS = 32;

	// request codes
	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_DEDUP = 2'd2
	} op_t;

	// result kinds
	typedef enum logic [2:0] {
		KIND_POP     = 3'd0,
		KIND_EMPTY   = 3'd1,
		KIND_REMOVED = 3'd2,
		KIND_DONE    = 3'd3,
		KIND_FULL    = 3'd4
	} kind_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_POP_OUT,
		ST_DD_I,
		ST_DD_IV,
		ST_DD_J,
		ST_DD_JC,
		ST_CP_RD,
		ST_CP_WR,
		ST_CP_END
	} state_t;

	// one result handed from the controller to the output register
	typedef struct packed {
		logic              vld;
		kind_t             kind;
		logic [DATA_W-1:0] data;
		logic              last;
	} res_t;

endpackage

// ===== rtl/core/swdr_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
module swdr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/swdr_ctrl.sv =====
// request sequencer: push, pop, duplicate scan and compaction over the entry ram
module swdr_ctrl #(
	parameter int STACK_DEPTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          in_op,
	input  logic [swdr_pkg::DATA_W-1:0]         in_value,
	input  logic                                out_free,
	output swdr_pkg::res_t                      res,
	output logic                                mem_we,
	output logic [$clog2(STACK_DEPTH)-1:0]      mem_waddr,
	output logic [swdr_pkg::DATA_W-1:0]         mem_wdata,
	output logic                                mem_re,
	output logic [$clog2(STACK_DEPTH)-1:0]      mem_raddr,
	input  logic [swdr_pkg::DATA_W-1:0]         mem_rdata
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	swdr_pkg::state_t state_q, state_d;
	swdr_pkg::op_t    op;

	logic [CW-1:0]                  count_q;
	logic [AW-1:0]                  i_q;
	logic [AW-1:0]                  j_q;
	logic [CW-1:0]                  k_q;
	logic [CW-1:0]                  wp_q;
	logic [CW-1:0]                  n_q;
	logic [swdr_pkg::DATA_W-1:0]    v_q;
	logic [STACK_DEPTH-1:0]         rm_q;

	logic acc;
	logic full;
	logic empty;
	logic hit;
	logic hit_stall;
	logic can_report;

	assign op         = swdr_pkg::op_t'(in_op);
	assign in_ready   = (state_q == swdr_pkg::ST_IDLE) && out_free;
	assign acc        = in_valid && in_ready;
	assign full       = (count_q == CW'(STACK_DEPTH));
	assign empty      = (count_q == '0);
	assign hit        = (mem_rdata == v_q);
	assign hit_stall  = hit && !out_free;
	assign can_report = (32'(n_q) < 32'(swdr_pkg::MAX_RESULTS - 1));

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swdr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory accesses and results
	always_comb begin
		state_d   = state_q;
		res       = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			swdr_pkg::ST_IDLE: begin
				if (acc) begin
					case (op)
						swdr_pkg::OP_PUSH: begin
							if (full) begin
								res.vld  = 1'b1;
								res.kind = swdr_pkg::KIND_FULL;
								res.last = 1'b1;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = count_q[AW-1:0];
								mem_wdata = in_value;
							end
						end
						swdr_pkg::OP_POP: begin
							if (empty) begin
								res.vld  = 1'b1;
								res.kind = swdr_pkg::KIND_EMPTY;
								res.last = 1'b1;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = AW'(count_q - CW'(1));
								state_d   = swdr_pkg::ST_POP_OUT;
							end
						end
						swdr_pkg::OP_DEDUP: begin
							if (count_q < CW'(2)) begin
								res.vld  = 1'b1;
								res.kind = swdr_pkg::KIND_DONE;
								res.last = 1'b1;
							end else begin
								state_d = swdr_pkg::ST_DD_I;
							end
						end
						default: begin
						end
					endcase
				end
			end
			swdr_pkg::ST_POP_OUT: begin
				res.vld  = 1'b1;
				res.kind = swdr_pkg::KIND_POP;
				res.data = mem_rdata;
				res.last = 1'b1;
				state_d  = swdr_pkg::ST_IDLE;
			end
			swdr_pkg::ST_DD_I: begin
				if (i_q == '0) begin
					state_d = swdr_pkg::ST_CP_RD;
				end else if (!rm_q[i_q]) begin
					mem_re    = 1'b1;
					mem_raddr = i_q;
					state_d   = swdr_pkg::ST_DD_IV;
				end
			end
			swdr_pkg::ST_DD_IV: begin
				state_d = swdr_pkg::ST_DD_J;
			end
			swdr_pkg::ST_DD_J: begin
				if (rm_q[j_q]) begin
					if (j_q == '0) begin
						state_d = swdr_pkg::ST_DD_I;
					end
				end else begin
					mem_re    = 1'b1;
					mem_raddr = j_q;
					state_d   = swdr_pkg::ST_DD_JC;
				end
			end
			swdr_pkg::ST_DD_JC: begin
				if (!hit_stall) begin
					if (hit && can_report) begin
						res.vld  = 1'b1;
						res.kind = swdr_pkg::KIND_REMOVED;
						res.data = mem_rdata;
					end
					state_d = (j_q == '0) ? swdr_pkg::ST_DD_I : swdr_pkg::ST_DD_J;
				end
			end
			swdr_pkg::ST_CP_RD: begin
				if (k_q == count_q) begin
					state_d = swdr_pkg::ST_CP_END;
				end else if (!rm_q[k_q[AW-1:0]]) begin
					mem_re    = 1'b1;
					mem_raddr = k_q[AW-1:0];
					state_d   = swdr_pkg::ST_CP_WR;
				end
			end
			swdr_pkg::ST_CP_WR: begin
				mem_we    = 1'b1;
				mem_waddr = wp_q[AW-1:0];
				mem_wdata = mem_rdata;
				state_d   = swdr_pkg::ST_CP_RD;
			end
			swdr_pkg::ST_CP_END: begin
				if (out_free) begin
					res.vld  = 1'b1;
					res.kind = swdr_pkg::KIND_DONE;
					res.last = 1'b1;
					state_d  = swdr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = swdr_pkg::ST_IDLE;
			end
		endcase
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (state_q)
				swdr_pkg::ST_IDLE: begin
					if (acc && op == swdr_pkg::OP_PUSH && !full) begin
						count_q <= count_q + CW'(1);
					end else if (acc && op == swdr_pkg::OP_POP && !empty) begin
						count_q <= count_q - CW'(1);
					end
				end
				swdr_pkg::ST_CP_END: begin
					if (out_free) begin
						count_q <= wp_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// scan and compaction indexes, removal flags, report count and the value under comparison
	always_ff @(posedge clk) begin
		case (state_q)
			swdr_pkg::ST_IDLE: begin
				if (acc && op == swdr_pkg::OP_DEDUP) begin
					i_q  <= AW'(count_q - CW'(1));
					rm_q <= '0;
					n_q  <= '0;
					k_q  <= '0;
					wp_q <= '0;
				end
			end
			swdr_pkg::ST_DD_I: begin
				if (i_q != '0 && rm_q[i_q]) begin
					i_q <= i_q - AW'(1);
				end
			end
			swdr_pkg::ST_DD_IV: begin
				v_q <= mem_rdata;
				j_q <= i_q - AW'(1);
			end
			swdr_pkg::ST_DD_J: begin
				if (rm_q[j_q]) begin
					if (j_q == '0) begin
						i_q <= i_q - AW'(1);
					end else begin
						j_q <= j_q - AW'(1);
					end
				end
			end
			swdr_pkg::ST_DD_JC: begin
				if (!hit_stall) begin
					if (hit) begin
						rm_q[j_q] <= 1'b1;
						if (can_report) begin
							n_q <= n_q + CW'(1);
						end
					end
					if (j_q == '0) begin
						i_q <= i_q - AW'(1);
					end else begin
						j_q <= j_q - AW'(1);
					end
				end
			end
			swdr_pkg::ST_CP_RD: begin
				if (k_q != count_q && rm_q[k_q[AW-1:0]]) begin
					k_q <= k_q + CW'(1);
				end
			end
			swdr_pkg::ST_CP_WR: begin
				k_q  <= k_q + CW'(1);
				wp_q <= wp_q + CW'(1);
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/core/stack_with_duplicate_removal.sv =====
// Bounded stack of signed 32-bit values with push, pop and duplicate removal.
// Requests arrive on s_* (tuser = operation, tdata = value); results leave on
// m_* through one output register (tuser = kind, tdata = data, tlast = last).
// The entries live in one ram with one write port and one registered read
// port, so a pop reads the top entry and reports it from the POP_OUT state.
// A push writes the ram, and an error result is issued, in the cycle that
// accepts the request. Duplicate removal walks the stored entries from the top
// down, reads each kept entry and compares it with every kept entry below it,
// marking lower copies as removed; then it compacts the ram by copying each
// kept entry down, and closes with the done marker, which waits for a free
// output register; it also waits whenever a match finds that register full.
// One request is worked on at a time.
module stack_with_duplicate_removal #(
	parameter int STACK_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [1:0]  s_tuser,   // [1:0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] data
	output logic [2:0]  m_tuser,   // [2:0] kind
	output logic        m_tlast
);

	localparam int AW = $clog2(STACK_DEPTH);

	swdr_pkg::res_t                res;
	logic                          out_free;
	logic                          mem_we;
	logic [AW-1:0]                 mem_waddr;
	logic [swdr_pkg::DATA_W-1:0]   mem_wdata;
	logic                          mem_re;
	logic [AW-1:0]                 mem_raddr;
	logic [swdr_pkg::DATA_W-1:0]   mem_rdata;

	logic                          m_valid_q;
	logic [swdr_pkg::DATA_W-1:0]   m_data_q;
	logic [2:0]                    m_kind_q;
	logic                          m_last_q;

	assign out_free = !m_valid_q || m_tready;

	// request sequencer
	swdr_ctrl #(
		.STACK_DEPTH(STACK_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (s_tuser),
		.in_value (s_tdata),
		.out_free (out_free),
		.res      (res),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	// stack entry storage
	swdr_ram #(
		.WIDTH(swdr_pkg::DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res.vld) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (res.vld) begin
			m_data_q <= res.data;
			m_kind_q <= res.kind;
			m_last_q <= res.last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;

endmodule

// ===== tb/tb.sv =====
// testbench for the stack with duplicate removal: random streams checked against a predictor
module tb;
	import swdr_pkg::*;

	localparam int  DEPTH          = 32;
	localparam int  CLK_PERIOD     = 12;
	localparam int  RESET_CYCLES   = 8;
	localparam int  RANDOM_ITEMS   = 85;
	localparam int  HOLD_CYCLES    = 150;
	localparam int  DRAIN_CYCLES   = 40;
	localparam int  TIMEOUT_CYCLES = 600000;
	// code the block must ignore
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// one expected result of a request
	typedef struct {
		kind_t       kind;
		logic [31:0] data;
		logic        last;
	} stack_result_t;

	// predicts the stack and checks the result stream in order
	class stack_scoreboard;
		logic [31:0]   entries [DEPTH];
		int            fill;
		stack_result_t expected [$];
		int            failures;
		int            checked;
		int            op_seen [4];
		int            removals;
		int            full_errors;
		int            empty_errors;
		int            peak;

		function new();
			fill         = 0;
			failures     = 0;
			checked      = 0;
			removals     = 0;
			full_errors  = 0;
			empty_errors = 0;
			peak         = 0;
			foreach (op_seen[k]) op_seen[k] = 0;
		endfunction

		function int pending();
			return expected.size();
		endfunction

		function void add(kind_t kind, logic [31:0] data, logic last);
			stack_result_t r;
			r.kind = kind;
			r.data = data;
			r.last = last;
			expected.push_back(r);
		endfunction

		// work out the results of one accepted request
		function void note_request(logic [1:0] op, logic [31:0] value);
			int          top;
			int          below;
			int          reported;
			logic [31:0] removed;
			op_seen[op]++;
			case (op)
				OP_PUSH: begin
					if (fill >= DEPTH) begin
						full_errors++;
						add(KIND_FULL, '0, 1'b1);
					end else begin
						entries[fill] = value;
						fill++;
						if (fill > peak) peak = fill;
					end
				end
				OP_POP: begin
					if (fill == 0) begin
						empty_errors++;
						add(KIND_EMPTY, '0, 1'b1);
					end else begin
						fill--;
						add(KIND_POP, entries[fill], 1'b1);
					end
				end
				OP_DEDUP: begin
					// keep the topmost copy, drop lower copies top-down
					reported = 0;
					top      = fill - 1;
					while (top >= 1) begin
						below = top - 1;
						while (below >= 0) begin
							if (entries[below] == entries[top]) begin
								removed = entries[below];
								for (int k = below; k < fill - 1; k++)
									entries[k] = entries[k + 1];
								fill--;
								top--;
								removals++;
								if (reported < MAX_RESULTS - 1) begin
									add(KIND_REMOVED, removed, 1'b0);
									reported++;
								end
							end
							below--;
						end
						top--;
					end
					add(KIND_DONE, '0, 1'b1);
				end
				default: ;
			endcase
		endfunction

		// compare one accepted result with the oldest expectation
		function void check_result(logic [2:0] kind, logic [31:0] data, logic last);
			stack_result_t e;
			checked++;
			if (expected.size() == 0) begin
				failures++;
				$display("%0t: result with nothing expected: kind %0d data %h last %b",
					$time, kind, data, last);
				return;
			end
			e = expected.pop_front();
			if (kind !== e.kind) begin
				failures++;
				$display("%0t: kind mismatch, expected %0d, got %0d", $time, e.kind, kind);
			end
			if (data !== e.data) begin
				failures++;
				$display("%0t: data mismatch, expected %h, got %h", $time, e.data, data);
			end
			if (last !== e.last) begin
				failures++;
				$display("%0t: last mismatch, expected %b, got %b", $time, e.last, last);
			end
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = OP_PUSH;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	stack_scoreboard sb = new();
	logic [31:0]     value_pool [4];
	int              items       = 0;
	bit              calm        = 1'b0;
	int              hold_len    = 0;
	bit              output_held = 1'b0;

	stack_with_duplicate_removal #(
		.STACK_DEPTH(DEPTH)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	// clock
	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// pool values repeat often so scans find duplicates
	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 99) < 65) return value_pool[$urandom_range(0, 3)];
		return $urandom();
	endfunction

	function automatic void refresh_pool();
		foreach (value_pool[k]) begin
			case ($urandom_range(0, 7))
				0:       value_pool[k] = 32'h8000_0000;
				1:       value_pool[k] = 32'h7fff_ffff;
				2:       value_pool[k] = 32'hffff_ffff;
				3:       value_pool[k] = 32'h0000_0000;
				default: value_pool[k] = $urandom();
			endcase
		end
	endfunction

	// offer one request, return at the edge that accepts it
	task automatic send(logic [1:0] op, logic [31:0] value);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= value;
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		sb.note_request(op, value);
		if (op != OP_UNUSED) items++;
		@(posedge clk);
	endtask

	// pause the sender until every result has come back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic fill_to(int level, int distinct);
		while (sb.fill < level)
			send(OP_PUSH, value_pool[$urandom_range(0, distinct - 1)]);
	endtask

	task automatic mixed_burst();
		int r;
		repeat ($urandom_range(4, 12)) begin
			r = $urandom_range(0, 99);
			if (r < 50)      send(OP_PUSH, pick_value());
			else if (r < 78) send(OP_POP, $urandom());
			else if (r < 94) send(OP_DEDUP, $urandom());
			else             send(OP_UNUSED, $urandom());
		end
	endtask

	// hold the output long enough that the block backs up into its input
	task automatic stall_output();
		repeat (6) send(OP_PUSH, pick_value());
		hold_len = HOLD_CYCLES;
		s_tvalid <= 1'b0;
		do @(posedge clk); while (!output_held);
		repeat (3) send(OP_POP, $urandom());
		send(OP_DEDUP, $urandom());
		repeat (3) send(OP_POP, $urandom());
		send(OP_POP, $urandom());
	endtask

	// result receiver: random stalls, plus the long hold on request
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_len > 0) begin
				m_tready    <= 1'b0;
				output_held = 1'b1;
				repeat (hold_len) @(posedge clk);
				hold_len    = 0;
				output_held = 1'b0;
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				stall = pick_gap();
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	// result monitor: values at the falling edge hold through the next rising edge
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata, m_tlast);
	end

	// stimulus
	initial begin
		int target;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty cases, ignored code, field extremes, one scan, drain past empty
		send(OP_POP, 32'hffff_ffff);
		send(OP_DEDUP, 32'h0);
		send(OP_UNUSED, 32'h1234_5678);
		send(OP_PUSH, 32'h7fff_ffff);
		send(OP_DEDUP, 32'h0);
		send(OP_PUSH, 32'h8000_0000);
		send(OP_PUSH, 32'h0000_0000);
		send(OP_PUSH, 32'hffff_ffff);
		send(OP_PUSH, 32'h7fff_ffff);
		send(OP_PUSH, 32'h8000_0000);
		send(OP_PUSH, 32'hffff_ffff);
		send(OP_DEDUP, 32'hffff_ffff);
		repeat (5) send(OP_POP, 32'h0);
		send(OP_PUSH, 32'h5555_5555);
		send(OP_PUSH, 32'haaaa_aaaa);
		send(OP_POP, 32'h0);
		send(OP_POP, 32'h0);
		wait_idle();

		// full stack of one value: full error, then the longest scan report
		refresh_pool();
		fill_to(DEPTH, 1);
		send(OP_PUSH, 32'h0);
		send(OP_DEDUP, 32'h0);
		send(OP_POP, 32'h0);
		send(OP_POP, 32'h0);
		stall_output();

		target = items + RANDOM_ITEMS;
		while (items < target) begin
			calm = ($urandom_range(0, 4) == 0);
			refresh_pool();
			case ($urandom_range(0, 9))
				0, 1, 2, 3: mixed_burst();
				4, 5: begin
					fill_to($urandom_range(sb.fill, DEPTH / 2), $urandom_range(1, 4));
					send(OP_DEDUP, $urandom());
				end
				6: begin
					fill_to(DEPTH, $urandom_range(2, 4));
					repeat ($urandom_range(1, 2)) send(OP_PUSH, pick_value());
					send(OP_DEDUP, $urandom());
				end
				7: begin
					while (sb.fill > 0) send(OP_POP, $urandom());
					send(OP_POP, $urandom());
				end
				8: begin
					wait_idle();
					mixed_burst();
				end
				default: stall_output();
			endcase
		end

		// let everything drain
		calm = 1'b0;
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("requests: %0d push, %0d pop, %0d scan, %0d ignored; %0d results checked",
			sb.op_seen[OP_PUSH], sb.op_seen[OP_POP], sb.op_seen[OP_DEDUP],
			sb.op_seen[OP_UNUSED], sb.checked);
		$display("%0d duplicates removed, %0d full and %0d empty errors, deepest stack %0d",
			sb.removals, sb.full_errors, sb.empty_errors, sb.peak);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("timeout with %0d results still expected", sb.pending());
		$display("Test completed with failures");
		$finish;
	end

endmodule
